@@ hw/rtl/top_k_tracker_with_sum_unit_macros.svh @@
// Assertion macros used by the checker file of the top-k tracker.
`ifndef TOP_K_TRACKER_WITH_SUM_UNIT_MACROS_SVH
`define TOP_K_TRACKER_WITH_SUM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TKTS_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("top-k tracker check failed");

// Next-cycle implication, disabled while reset is high.
`define TKTS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("top-k tracker check failed");

`endif

@@ hw/rtl/tkts_pkg.sv @@
`timescale 1ns / 1ps

package tkts_pkg;

   // Field widths.
   localparam int VALUE_W = 32;
   localparam int SUM_W   = 38;
   localparam int HELD_W  = 7;
   localparam int DELTA_W = VALUE_W + 1;

   // Stream data widths, padded to whole bytes.
   localparam int REQ_DATA_W = 32;
   localparam int RSP_FIELD_W = SUM_W + VALUE_W + HELD_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_DATA_W - RSP_FIELD_W;

   // Default chain depth and capacity register reset value.
   localparam int DEPTH_DEFAULT = 64;
   localparam logic [HELD_W-1:0] KEEP_RESET = 7'd64;

   // Operation broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_INSERT  = 2'd1,
      OP_REPLACE = 2'd2
   } tkts_op_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic                      gt;   // empty, or holds more than the sample
      logic                      le;   // holds at most the sample
   } tkts_link_type;

   localparam tkts_link_type EDGE_LINK = '{valid: 1'b0, value: '0, gt: 1'b0, le: 1'b0};

endpackage

@@ hw/rtl/tkts_cell.sv @@
`timescale 1ns / 1ps

// One slot of the ascending sorted chain. The smallest value sits in cell 0.
module tkts_cell
   import tkts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  tkts_op_type               op,
   input  logic signed [VALUE_W-1:0] sample,
   input  tkts_link_type             left_link,
   input  tkts_link_type             right_link,
   output tkts_link_type             self_link
);

   logic                      valid_ff;
   logic                      valid_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      gt;
   logic                      le;

   // Compare against the broadcast sample.
   assign gt = !valid_ff || (value_ff > sample);
   assign le = valid_ff && (value_ff <= sample);

   assign self_link = '{valid: valid_ff, value: value_ff, gt: gt, le: le};

   // Insert shifts larger values up; replace drops cell 0 and shifts smaller values down.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (op)
         OP_INSERT: begin
            if (left_link.gt) begin
               valid_in = left_link.valid;
               value_in = left_link.value;
            end else if (gt) begin
               valid_in = 1'b1;
               value_in = sample;
            end
         end
         OP_REPLACE: begin
            if (right_link.le) begin
               valid_in = right_link.valid;
               value_in = right_link.value;
            end else if (le) begin
               valid_in = 1'b1;
               value_in = sample;
            end
         end
         default: begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
      endcase
   end

   // Occupancy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stored value.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ hw/rtl/top_k_tracker_with_sum_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// req_      in         value
// rsp_      out        kept_sum, smallest_kept, held
// csr_      in         keep_count (write only)
//
// One beat is taken per cycle when the result side keeps up.
// A beat is ranked into the cell chain in the cycle it is taken; its sum change
// is registered, and the sum is updated and the result registered once the result
// register is free. The chain update sets the rate.
// Reset empties the chain and clears the count and sum.
// A stalled result holds the next beat back once one beat waits for the sum stage.
module top_k_tracker_with_sum_unit
   import tkts_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [37:0] kept_sum, [69:38] smallest_kept,
                                              // [76:70] held, [79:77] zero
   input  logic                  csr_we,
   input  logic [HELD_W-1:0]     csr_wdata    // [6:0] keep_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > HELD_W) ? CNT_W : HELD_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
   localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1);

   logic [HELD_W-1:0]         keep_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [DELTA_W-1:0] delta_ff;
   logic signed [DELTA_W-1:0] delta_in;
   logic                      pend_ff;
   logic                      rsp_valid_ff;
   logic signed [SUM_W-1:0]   rsp_sum_ff;
   logic signed [VALUE_W-1:0] rsp_min_ff;
   logic [HELD_W-1:0]         rsp_held_ff;

   logic                      accept;
   logic                      out_free;
   logic                      fire;
   logic [CMP_W-1:0]          keep_ext;
   logic [CMP_W-1:0]          cap;
   logic                      not_full;
   logic signed [VALUE_W-1:0] sample;
   tkts_op_type               op;
   tkts_link_type             links [DEPTH];
   tkts_link_type             head;

   assign sample   = $signed(req_tdata[VALUE_W-1:0]);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fire     = pend_ff && out_free;
   assign req_tready = !pend_ff || out_free;
   assign accept   = req_tvalid && req_tready;
   assign head     = links[0];

   // Effective capacity: zero acts as one, anything above the depth as the depth.
   assign keep_ext = CMP_W'(keep_ff);
   always_comb begin
      if (keep_ext == '0) begin
         cap = ONE_C;
      end else if (keep_ext > DEPTH_C) begin
         cap = DEPTH_C;
      end else begin
         cap = keep_ext;
      end
   end
   assign not_full = CMP_W'(count_ff) < cap;

   // Choose the chain operation and the change to the sum for this beat.
   always_comb begin
      op       = OP_HOLD;
      delta_in = '0;
      count_in = count_ff;
      if (accept) begin
         if (not_full) begin
            op       = OP_INSERT;
            delta_in = DELTA_W'(sample);
            count_in = count_ff + CNT_W'(1);
         end else if (head.valid && (sample > head.value)) begin
            op       = OP_REPLACE;
            delta_in = DELTA_W'(sample) - DELTA_W'(head.value);
         end
      end
   end

   assign sum_in = sum_ff + SUM_W'(delta_ff);

   // Sorted chain of cells.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      tkts_link_type left_link;
      tkts_link_type right_link;
      if (i == 0) begin : g_first
         assign left_link = EDGE_LINK;
      end else begin : g_mid_l
         assign left_link = links[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_link = EDGE_LINK;
      end else begin : g_mid_r
         assign right_link = links[i+1];
      end
      tkts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .sample     (sample),
         .left_link  (left_link),
         .right_link (right_link),
         .self_link  (links[i])
      );
   end

   // Control state: capacity, count, sum and handshake flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff      <= KEEP_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            keep_ff <= csr_wdata;
         end
         count_ff <= count_in;
         if (fire) begin
            sum_ff <= sum_in;
         end
         if (accept) begin
            pend_ff <= 1'b1;
         end else if (fire) begin
            pend_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Sum change carried to the result stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         delta_ff <= delta_in;
      end
   end

   // Result register; the chain and count already reflect the pending beat.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_sum_ff  <= sum_in;
         rsp_min_ff  <= head.valid ? head.value : '0;
         rsp_held_ff <= HELD_W'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_held_ff, rsp_min_ff, rsp_sum_ff};

endmodule

@@ hw/rtl/tkts_checker.sv @@
`timescale 1ns / 1ps
`include "top_k_tracker_with_sum_unit_macros.svh"

// Port-level checks of the top-k tracker.
module tkts_checker
   import tkts_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                      req_beat;
   logic                      rsp_stall;
   logic                      rsp_one;
   logic                      rsp_empty;
   logic                      sum_is_min;
   logic signed [SUM_W-1:0]   chk_sum;
   logic signed [VALUE_W-1:0] chk_min;
   logic [HELD_W-1:0]         chk_held;

   assign req_beat   = req_tvalid && req_tready;
   assign chk_sum    = $signed(rsp_tdata[SUM_W-1:0]);
   assign chk_min    = $signed(rsp_tdata[SUM_W+VALUE_W-1:SUM_W]);
   assign chk_held   = rsp_tdata[RSP_FIELD_W-1:SUM_W+VALUE_W];
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_one    = rsp_tvalid && (chk_held == HELD_W'(1));
   assign rsp_empty  = rsp_tvalid && (chk_held == '0);
   assign sum_is_min = chk_sum == SUM_W'(chk_min);

   // A stalled result holds its beat.
   `TKTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // A taken beat must be followed by a valid result.
   `TKTS_ASSERT_IMPLY(a_rsp_follows, clock, reset, req_beat, ##2 rsp_tvalid)

   // Input back-pressure only arises behind a waiting result.
   `TKTS_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_tready, rsp_tvalid)

   // With a single value held, the sum is that value.
   `TKTS_ASSERT_IMPLY(a_single_sum, clock, reset, rsp_one, sum_is_min)

   // An empty store reports a zero minimum.
   `TKTS_ASSERT_IMPLY(a_empty_min, clock, reset, rsp_empty, chk_min == '0)

endmodule

bind top_k_tracker_with_sum_unit tkts_checker u_tkts_checker (.*);

@@ verif/top_k_tracker_with_sum_unit_tb.sv @@
`timescale 1ns / 1ps

module top_k_tracker_with_sum_unit_tb;
   import tkts_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 6;

   // One expected result beat.
   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [VALUE_W-1:0] smallest;
      logic [HELD_W-1:0]  held;
   } tally_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [31:0] value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [37:0] kept_sum, [69:38] smallest_kept,
                                            // [76:70] held, [79:77] zero
   logic                  csr_we = 1'b0;
   logic [HELD_W-1:0]     csr_wdata = '0;   // [6:0] keep_count

   // Shadow copy of the store, the count, the sum and the capacity register.
   logic signed [VALUE_W-1:0] model_vals [DEPTH_DEFAULT];
   int                        model_held = 0;
   logic [SUM_W-1:0]          model_sum = '0;
   logic [HELD_W-1:0]         model_keep = KEEP_RESET;

   tally_type expected_tallies [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int samples_sent = 0;
   int tallies_checked = 0;
   int replacements = 0;
   int ties_dropped = 0;
   int cycle_count = 0;

   top_k_tracker_with_sum_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit, counted in clock cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Result side back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Compare every accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      tally_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tallies.size() == 0) begin
            report_mismatch("unexpected result beat", 64'(rsp_tdata), '0);
         end else begin
            want = expected_tallies.pop_front();
            tallies_checked++;
            if (rsp_tdata[SUM_W-1:0] !== want.sum)
               report_mismatch("kept_sum", 64'(rsp_tdata[SUM_W-1:0]), 64'(want.sum));
            if (rsp_tdata[SUM_W +: VALUE_W] !== want.smallest)
               report_mismatch("smallest_kept", 64'(rsp_tdata[SUM_W +: VALUE_W]),
                               64'(want.smallest));
            if (rsp_tdata[SUM_W+VALUE_W +: HELD_W] !== want.held)
               report_mismatch("held", 64'(rsp_tdata[SUM_W+VALUE_W +: HELD_W]),
                               64'(want.held));
            if (rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W] !== '0)
               report_mismatch("padding", 64'(rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W]), '0);
         end
      end
   end

   // Slot of the smallest held value; the store must not be empty.
   function automatic int lowest_slot();
      int best;
      best = 0;
      for (int i = 1; i < model_held; i++) begin
         if (model_vals[i] < model_vals[best]) best = i;
      end
      return best;
   endfunction

   function automatic logic signed [VALUE_W-1:0] current_floor();
      return (model_held > 0) ? model_vals[lowest_slot()] : '0;
   endfunction

   function automatic logic [SUM_W-1:0] widen(input logic [VALUE_W-1:0] v);
      return {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
   endfunction

   // Rank one accepted sample into the shadow store and queue its result.
   function automatic void rank_sample(input logic signed [VALUE_W-1:0] v);
      int        cap;
      int        lo;
      tally_type t;
      cap = (model_keep == 0) ? 1 :
            ((model_keep > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(model_keep));
      if (model_held < cap) begin
         model_vals[model_held] = v;
         model_held++;
         model_sum = model_sum + widen(v);
      end else if (model_held > 0) begin
         lo = lowest_slot();
         if (v > model_vals[lo]) begin
            model_sum = model_sum - widen(model_vals[lo]) + widen(v);
            model_vals[lo] = v;
            replacements++;
         end else if (v == model_vals[lo]) begin
            ties_dropped++;
         end
      end
      t.sum = model_sum;
      t.smallest = current_floor();
      t.held = HELD_W'(model_held);
      expected_tallies.push_back(t);
   endfunction

   // Offer one sample; returns at the edge where the beat is taken.
   task automatic send_sample(input logic signed [VALUE_W-1:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      rank_sample(v);
      samples_sent++;
   endtask

   // Let every result come back, then let the pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_tallies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Capacity writes happen only with the block idle.
   task automatic write_keep_count(input logic [HELD_W-1:0] k);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= k;
      @(posedge clock);
      csr_we <= 1'b0;
      model_keep = k;
   endtask

   // Random sample, biased toward the current minimum so that ties and
   // replacements keep happening once the store is full.
   function automatic logic signed [VALUE_W-1:0] pick_sample();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(9))
         4, 5: v = current_floor() + (int'($urandom_range(6)) - 3);
         6: begin
            case ($urandom_range(3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = '0;
               default: v = '1;
            endcase
         end
         7, 8: v = int'($urandom_range(200)) - 100;
         9: v = current_floor();
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // A capacity of zero acts as one; ties and smaller values are dropped.
   task automatic test_single_slot();
      write_keep_count('0);
      send_sample(-5);
      send_sample(-5);
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      write_keep_count(7'd1);
      send_sample(-1);
      send_sample(32'h7FFF_FFFF);
   endtask

   // Both ends of the value range held together, then middle values pushing out
   // the most negative ones, and a most negative sample dropped.
   task automatic test_value_extremes();
      write_keep_count(7'd4);
      send_sample(32'h8000_0000);
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample('0);
      send_sample('0);
      send_sample(32'h8000_0000);
   endtask

   // Capacities above the depth act as the depth.
   task automatic test_oversized_capacity();
      write_keep_count(7'd127);
      for (int i = 0; i < 5; i++) send_sample(32'h7FFF_FFFF - i);
      write_keep_count(7'd65);
      for (int i = 0; i < 5; i++) send_sample(32'h8000_0000 + i);
   endtask

   task automatic test_random_stream(input int count, input int send_pct,
                                     input int recv_pct, input logic [HELD_W-1:0] k);
      write_keep_count(k);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) send_sample(pick_sample());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_slot();
      test_value_extremes();
      test_oversized_capacity();

      // Capacity mid, full depth, far below the count held, full depth, then one.
      test_random_stream(400, 34, 71, HELD_W'($urandom_range(20, 40)));
      test_random_stream(200, 34, 71, 7'd64);
      test_random_stream(580, 71, 34, HELD_W'($urandom_range(1, 8)));
      test_random_stream(290, 0, 0, 7'd64);
      test_random_stream(290, 0, 0, 7'd1);

      drain();
      recv_idle_pct = 0;
      $display("covered %0d samples over capacities 0 to 127, %0d results checked",
               samples_sent, tallies_checked);
      $display("minimum replaced %0d times, equal samples dropped %0d times",
               replacements, ties_dropped);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/tkts_pkg.sv
hw/rtl/tkts_cell.sv
hw/rtl/top_k_tracker_with_sum_unit.sv
hw/rtl/tkts_checker.sv
verif/top_k_tracker_with_sum_unit_tb.sv
